// File: rtl/lzo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzo_pkg
// Shared constants and types for the layer z-order stack.
// ----------------------------------------------------------------------------
package lzo_pkg;
  localparam int MaxLayers = 16;
  localparam int SlotW = $clog2(MaxLayers);
  localparam int CntW = $clog2(MaxLayers + 1);

  localparam logic [2:0] ActDefine = 3'd0;
  localparam logic [2:0] ActMoveAbs = 3'd1;
  localparam logic [2:0] ActMoveRel = 3'd2;
  localparam logic [2:0] ActHeight = 3'd3;
  localparam logic [2:0] ActHide = 3'd4;
  localparam logic [2:0] ActHit = 3'd5;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0] w;
    logic [11:0] h;
    logic win;
  } rect_t;
endpackage

// File: rtl/lzo_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzo_cell
// One stack position: holds a slot number and shifts it toward a neighbor.
// ----------------------------------------------------------------------------
module lzo_cell import lzo_pkg::*; (
  input  logic clk,
  input  logic load,
  input  logic [SlotW-1:0] load_slot,
  input  logic shift_up,
  input  logic shift_dn,
  input  logic [SlotW-1:0] from_below,
  input  logic [SlotW-1:0] from_above,
  output logic [SlotW-1:0] slot
);
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= load_slot;
    end else if (shift_up) begin
      slot <= from_below;
    end else if (shift_dn) begin
      slot <= from_above;
    end
  end
endmodule

// File: rtl/layer_z_order_stack_hit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_z_order_stack_hit_test
// Layer table with a back-to-front visible stack and a front-first hit test.
//
// Channel   Direction  Handshake
// command   in         start && !busy
// result    out        done, one cycle
//
// Busy falls in the result cycle. Set height and hide search one stack position
// per cycle, then remove the layer if it is in the stack; set height with a
// non-negative height then inserts it.
// Reset clears the layer table marks and the stack count.
// The receiver cannot stall; results appear on done for one cycle.
// ----------------------------------------------------------------------------
module layer_z_order_stack_hit_test import lzo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [2:0] action,
  input  logic [4:0] layer_id,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic [11:0] size_w,
  input  logic [11:0] size_h,
  input  logic has_window,
  input  logic signed [5:0] stack_height,
  input  logic [4:0] skip_id,
  output logic done,
  output logic found,
  output logic [4:0] hit_layer_id,
  output logic error,
  output logic [4:0] visible_count
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFind = 3'd1;
  localparam logic [2:0] StRemove = 3'd2;
  localparam logic [2:0] StInsert = 3'd3;
  localparam logic [2:0] StHit = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  rect_t tbl [MaxLayers];
  logic [MaxLayers-1:0] defd;
  logic [2:0] state;
  logic [2:0] act;
  logic [SlotW-1:0] sl;
  logic signed [15:0] px, py;
  logic signed [6:0] hgt;
  logic [4:0] excl;
  logic [CntW-1:0] cnt, idx, tgt;
  logic [SlotW-1:0] slots [MaxLayers];
  logic [MaxLayers-1:0] ld, su, sd;

  logic id_ok;
  assign id_ok = (layer_id != 5'd0) && ({1'b0, layer_id} <= 6'(MaxLayers));
  logic [SlotW-1:0] in_sl;
  assign in_sl = SlotW'(layer_id - 5'd1);

  genvar g;
  generate
    for (g = 0; g < MaxLayers; g++) begin : g_cell
      lzo_cell u_cell (
        .clk(clk), .load(ld[g]), .load_slot(sl), .shift_up(su[g]),
        .shift_dn(sd[g]),
        .from_below(slots[(g == 0) ? 0 : g - 1]),
        .from_above(slots[(g == MaxLayers - 1) ? g : g + 1]),
        .slot(slots[g])
      );
    end
  endgenerate

  logic [SlotW-1:0] cur;
  rect_t cr;
  logic signed [16:0] xe, ye;
  logic hit_now;
  assign cur = slots[idx[SlotW-1:0]];
  assign cr = tbl[cur];
  assign xe = 17'(cr.x) + 17'(signed'({5'd0, cr.w}));
  assign ye = 17'(cr.y) + 17'(signed'({5'd0, cr.h}));
  assign hit_now = cr.win && ({1'b0, cur} + 5'd1 != excl) && cr.x <= px &&
                   17'(px) < xe && cr.y <= py && 17'(py) < ye;

  logic signed [16:0] sx, sy;
  assign sx = 17'(tbl[in_sl].x) + 17'(coord_x);
  assign sy = 17'(tbl[in_sl].y) + 17'(coord_y);

  function automatic logic signed [15:0] sat(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'sh7fff;
    if (v < -17'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    ld = '0;
    su = '0;
    sd = '0;
    for (int i = 0; i < MaxLayers; i++) begin
      if (state == StRemove && idx + 1 < cnt && CntW'(i) >= idx && CntW'(i) + 1 < cnt)
        sd[i] = 1'b1;
      if (state == StInsert) begin
        if (idx > tgt && CntW'(i) > tgt && CntW'(i) <= idx) su[i] = 1'b1;
        if (idx == tgt && CntW'(i) == tgt) ld[i] = 1'b1;
      end
    end
  end

  assign busy = (state != StIdle);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= StIdle;
      defd <= '0;
      cnt <= '0;
      for (int i = 0; i < MaxLayers; i++) tbl[i].win <= 1'b0;
    end else begin
      case (state)
        StIdle: begin
          if (start) begin
            act <= action;
            sl <= in_sl;
            px <= coord_x;
            py <= coord_y;
            hgt <= 7'(stack_height);
            excl <= skip_id;
            found <= 1'b0;
            hit_layer_id <= '0;
            error <= 1'b0;
            idx <= '0;
            state <= StDone;
            if (action == ActHit) begin
              idx <= cnt;
              state <= StHit;
            end else if (action > ActHit) begin
              error <= 1'b1;
            end else if (!id_ok || (action != ActDefine && !defd[in_sl])) begin
              error <= 1'b1;
            end else if (action == ActDefine) begin
              tbl[in_sl] <= '{x: coord_x, y: coord_y, w: size_w, h: size_h,
                              win: has_window};
              defd[in_sl] <= 1'b1;
            end else if (action == ActMoveAbs) begin
              tbl[in_sl].x <= coord_x;
              tbl[in_sl].y <= coord_y;
            end else if (action == ActMoveRel) begin
              tbl[in_sl].x <= sat(sx);
              tbl[in_sl].y <= sat(sy);
            end else begin
              state <= StFind;
            end
          end
        end
        StFind: begin
          if (idx < cnt && cur == sl) begin
            state <= StRemove;
          end else if (idx + 1 < cnt) begin
            idx <= idx + 1'b1;
          end else begin
            // not in the stack
            if (act == ActHide || hgt < 0) begin
              state <= StDone;
            end else begin
              tgt <= (hgt > 7'(signed'({1'b0, cnt}))) ? cnt : CntW'(hgt);
              idx <= cnt;
              state <= (cnt < CntW'(MaxLayers)) ? StInsert : StDone;
            end
          end
        end
        StRemove: begin
          cnt <= cnt - 1'b1;
          if (act == ActHide || hgt < 0) begin
            state <= StDone;
          end else begin
            tgt <= (hgt >= 7'(signed'({1'b0, cnt}))) ? cnt - 1'b1 : CntW'(hgt);
            idx <= cnt - 1'b1;
            state <= StInsert;
          end
        end
        StInsert: begin
          if (idx == tgt) begin
            cnt <= cnt + 1'b1;
            state <= StDone;
          end else begin
            idx <= tgt;
          end
        end
        StHit: begin
          if (idx == '0) begin
            state <= StDone;
          end else begin
            idx <= idx - 1'b1;
            if (idx != cnt && hit_now) begin
              found <= 1'b1;
              hit_layer_id <= 5'({1'b0, cur} + 5'd1);
              state <= StDone;
            end
          end
          if (idx == '0 && idx != cnt && hit_now) begin
            found <= 1'b1;
            hit_layer_id <= 5'({1'b0, cur} + 5'd1);
          end
        end
        StDone: begin
          done <= 1'b1;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign visible_count = 5'(cnt);
endmodule

// File: test/lzo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzo_checker
// Watches the command and result channels of the layer z-order stack, keeps
// its own copy of the layer table and visible stack, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module lzo_checker import lzo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic [2:0] action,
  input  logic [4:0] layer_id,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic [11:0] size_w,
  input  logic [11:0] size_h,
  input  logic has_window,
  input  logic signed [5:0] stack_height,
  input  logic [4:0] skip_id,
  input  logic done,
  input  logic found,
  input  logic [4:0] hit_layer_id,
  input  logic error,
  input  logic [4:0] visible_count,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic found;
    logic [4:0] hit;
    logic error;
    logic [4:0] count;
  } answer_t;

  rect_t layers [MaxLayers];
  logic defined [MaxLayers];
  int order [MaxLayers];
  int depth;
  answer_t answers [$];

  assign pending = answers.size();

  function automatic int find_slot(int s);
    for (int i = 0; i < depth; i++) if (order[i] == s) return i;
    return depth;
  endfunction

  function automatic void pull_out(int at);
    for (int i = at; i + 1 < depth; i++) order[i] = order[i + 1];
    if (depth > 0) depth--;
  endfunction

  function automatic void put_in(int at, int s);
    if (depth >= MaxLayers || at > depth) return;
    for (int i = depth; i > at; i--) order[i] = order[i - 1];
    order[at] = s;
    depth++;
  endfunction

  function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    int sum;
    sum = int'(a) + int'(b);
    if (sum > 32767) return 16'sh7fff;
    if (sum < -32768) return 16'sh8000;
    return sum[15:0];
  endfunction

  function automatic answer_t apply_command();
    answer_t r;
    int s, p, t, l;
    bit id_ok;
    r = '0;
    id_ok = layer_id >= 1 && layer_id <= MaxLayers;
    s = id_ok ? layer_id - 1 : 0;
    if (action == ActHit) begin
      for (int i = depth - 1; i >= 0; i--) begin
        l = order[i];
        if (l + 1 == skip_id || !layers[l].win) continue;
        if (int'(layers[l].x) <= int'(coord_x) &&
            int'(coord_x) < int'(layers[l].x) + int'(layers[l].w) &&
            int'(layers[l].y) <= int'(coord_y) &&
            int'(coord_y) < int'(layers[l].y) + int'(layers[l].h)) begin
          r.found = 1'b1;
          r.hit = 5'(l + 1);
          break;
        end
      end
    end else if (action > ActHit) begin
      r.error = 1'b1;
    end else if (!id_ok || (action != ActDefine && !defined[s])) begin
      r.error = 1'b1;
    end else if (action == ActDefine) begin
      layers[s] = '{coord_x, coord_y, size_w, size_h, has_window};
      defined[s] = 1'b1;
    end else if (action == ActMoveAbs) begin
      layers[s].x = coord_x;
      layers[s].y = coord_y;
    end else if (action == ActMoveRel) begin
      layers[s].x = sat_add(layers[s].x, coord_x);
      layers[s].y = sat_add(layers[s].y, coord_y);
    end else if (action == ActHeight && stack_height >= 0) begin
      t = stack_height;
      if (t > depth) t = depth;
      p = find_slot(s);
      if (p >= depth) begin
        put_in(t, s);
      end else begin
        if (t == depth) t--;
        pull_out(p);
        put_in(t, s);
      end
    end else begin
      p = find_slot(s);
      if (p < depth) pull_out(p);
    end
    r.count = 5'(depth);
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (rst) begin
      for (int i = 0; i < MaxLayers; i++) begin
        layers[i] = '0;
        defined[i] = 1'b0;
        order[i] = 0;
      end
      depth = 0;
      fail_count = 0;
      answers.delete();
    end else begin
      if (done) begin
        got = '{found, hit_layer_id, error, visible_count};
        if (answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result transaction %p", got);
        end else begin
          want = answers.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("Mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (start && !busy) answers.push_back(apply_command());
    end
  end
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random layer commands into the z-order stack in bursts
// with random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import lzo_pkg::*;

  logic clk, rst, start, busy, done;
  logic [2:0] action;
  logic [4:0] layer_id, skip_id, hit_layer_id, visible_count;
  logic signed [15:0] coord_x, coord_y;
  logic [11:0] size_w, size_h;
  logic has_window, found, error;
  logic signed [5:0] stack_height;
  int fail_count, pending, cycles;

  layer_z_order_stack_hit_test DUT (.*);
  lzo_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic [2:0] a, logic [4:0] id, logic signed [15:0] x,
                      logic signed [15:0] y, logic [11:0] w, logic [11:0] h,
                      logic win, logic signed [5:0] ht, logic [4:0] ex);
    start <= 1'b1;
    action <= a;
    layer_id <= id;
    coord_x <= x;
    coord_y <= y;
    size_w <= w;
    size_h <= h;
    has_window <= win;
    stack_height <= ht;
    skip_id <= ex;
    do @(posedge clk); while (busy);
  endtask

  task automatic gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 120)) - 16'sd20;
    endcase
  endfunction

  initial begin
    int burst;
    logic [2:0] a;
    logic [4:0] id;
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    layer_id = '0;
    coord_x = '0;
    coord_y = '0;
    size_w = '0;
    size_h = '0;
    has_window = 1'b0;
    stack_height = '0;
    skip_id = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ActHide, 5'd3, 0, 0, 0, 0, 0, 0, 0);
    send(ActDefine, 5'd0, 0, 0, 1, 1, 1, 0, 0);
    send(ActDefine, 5'd17, 0, 0, 1, 1, 1, 0, 0);
    send(ActDefine, 5'd31, 0, 0, 1, 1, 1, 0, 0);
    send(ActDefine, 5'd1, 0, 0, 12'hfff, 12'hfff, 1, 0, 0);
    send(ActDefine, 5'd16, 10, 10, 5, 5, 1, 0, 0);
    send(ActDefine, 5'd2, 0, 0, 0, 0, 1, 0, 0);
    send(ActDefine, 5'd3, -5, -5, 20, 20, 0, 0, 0);
    send(ActHeight, 5'd1, 0, 0, 0, 0, 0, 6'sd31, 0);
    send(ActHeight, 5'd16, 0, 0, 0, 0, 0, 6'sd16, 0);
    send(ActHeight, 5'd2, 0, 0, 0, 0, 0, 6'sd0, 0);
    send(ActHeight, 5'd3, 0, 0, 0, 0, 0, 6'sd1, 0);
    send(ActHeight, 5'd1, 0, 0, 0, 0, 0, 6'sd20, 0);
    send(ActHit, 5'd0, 12, 12, 0, 0, 0, 0, 0);
    send(ActHit, 5'd0, 12, 12, 0, 0, 0, 0, 5'd1);
    send(ActHit, 5'd0, 15, 15, 0, 0, 0, 0, 5'd16);
    send(ActHit, 5'd0, 0, 0, 0, 0, 0, 0, 5'd31);
    send(ActMoveRel, 5'd1, 16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0);
    send(ActMoveRel, 5'd1, 16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0);
    send(ActMoveAbs, 5'd16, 16'sh8000, 16'sh7fff, 0, 0, 0, 0, 0);
    send(ActMoveAbs, 5'd5, 0, 0, 0, 0, 0, 0, 0);
    send(ActHeight, 5'd16, 0, 0, 0, 0, 0, -6'sd32, 0);
    send(ActHide, 5'd1, 0, 0, 0, 0, 0, 0, 0);
    send(3'd6, 5'd1, 0, 0, 0, 0, 0, 0, 0);
    send(3'd7, 5'd1, 0, 0, 0, 0, 0, 0, 0);

    for (int n = 0; n < 700; ) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int k = 0; k < burst && n < 700; k++, n++) begin
        a = $urandom_range(0, 20) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        id = $urandom_range(0, 30) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16));
        send(a, id, pick_coord(), pick_coord(),
             $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 60)),
             $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, 60)),
             $urandom_range(0, 4) != 0,
             $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 17)),
             $urandom_range(0, 2) == 0 ? 5'($urandom) : 5'($urandom_range(0, 16)));
      end
      gap();
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
